[design/lmls_pkg.sv]
`timescale 1ns / 1ps

package lmls_pkg;

    localparam int unsigned ELAPSED_W = 8;
    localparam int unsigned THRESH_W  = 10;
    localparam int unsigned DOT_W     = 11;
    localparam int unsigned LINE_W    = 8;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 16;
    localparam int unsigned M_USER_W  = 2;

    localparam logic [LINE_W-1:0]   VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0]   LAST_LINE     = 8'd153;
    localparam logic [THRESH_W-1:0] OAM_RESET     = 10'd80;
    localparam logic [THRESH_W-1:0] VRAM_RESET    = 10'd172;
    localparam logic [THRESH_W-1:0] HBLANK_RESET  = 10'd204;
    localparam logic [THRESH_W-1:0] VBLANK_RESET  = 10'd456;

    typedef enum logic [MODE_W-1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_VRAM   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OAM_CYCLES    = 2'd0,
        CFG_VRAM_CYCLES   = 2'd1,
        CFG_HBLANK_CYCLES = 2'd2,
        CFG_VBLANK_CYCLES = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [THRESH_W-1:0] oam_cycles;
        logic [THRESH_W-1:0] vram_cycles;
        logic [THRESH_W-1:0] hblank_cycles;
        logic [THRESH_W-1:0] vblank_line_cycles;
    } timing_cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [DOT_W-1:0]  dot_count;
        logic [LINE_W-1:0] line_count;
    } seq_state_t;

    typedef struct packed {
        logic render_line;
        logic vblank_irq;
    } seq_flags_t;

endpackage

[design/lmls_cfg_regs.sv]
`timescale 1ns / 1ps

module lmls_cfg_regs
    import lmls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [THRESH_W-1:0]  cfg_wdata,
    output timing_cfg_t          cfg
);

    timing_cfg_t cfg_reg;
    timing_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_OAM_CYCLES:    cfg_next.oam_cycles         = cfg_wdata;
                CFG_VRAM_CYCLES:   cfg_next.vram_cycles        = cfg_wdata;
                CFG_HBLANK_CYCLES: cfg_next.hblank_cycles      = cfg_wdata;
                CFG_VBLANK_CYCLES: cfg_next.vblank_line_cycles = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.oam_cycles         <= OAM_RESET;
            cfg_reg.vram_cycles        <= VRAM_RESET;
            cfg_reg.hblank_cycles      <= HBLANK_RESET;
            cfg_reg.vblank_line_cycles <= VBLANK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/lmls_step.sv]
`timescale 1ns / 1ps

module lmls_step
    import lmls_pkg::*;
(
    input  seq_state_t           cur,
    input  logic [ELAPSED_W-1:0] elapsed_cycles,
    input  timing_cfg_t          cfg,
    output seq_state_t           nxt,
    output seq_flags_t           flags
);

    logic [DOT_W-1:0]    dot_sum;
    logic [THRESH_W-1:0] thresh;
    logic [LINE_W-1:0]   line_inc;
    logic                done;

    assign dot_sum  = cur.dot_count + DOT_W'(elapsed_cycles);
    assign line_inc = cur.line_count + LINE_W'(1);

    always_comb
    begin
        case (cur.mode)
            MODE_OAM:    thresh = cfg.oam_cycles;
            MODE_VRAM:   thresh = cfg.vram_cycles;
            MODE_HBLANK: thresh = cfg.hblank_cycles;
            default:     thresh = cfg.vblank_line_cycles;
        endcase
    end

    assign done = dot_sum >= DOT_W'(thresh);

    always_comb
    begin
        nxt               = cur;
        nxt.dot_count     = dot_sum;
        flags.render_line = 1'b0;
        flags.vblank_irq  = 1'b0;
        if (done)
        begin
            nxt.dot_count = '0;
            case (cur.mode)
                MODE_OAM:
                begin
                    nxt.mode = MODE_VRAM;
                end
                MODE_VRAM:
                begin
                    nxt.mode          = MODE_HBLANK;
                    flags.render_line = 1'b1;
                end
                MODE_HBLANK:
                begin
                    nxt.line_count = line_inc;
                    if (line_inc == VISIBLE_LINES)
                    begin
                        nxt.mode         = MODE_VBLANK;
                        flags.vblank_irq = 1'b1;
                    end
                    else
                    begin
                        nxt.mode = MODE_OAM;
                    end
                end
                default:
                begin
                    nxt.line_count = line_inc;
                    if (line_inc > LAST_LINE)
                    begin
                        nxt.mode       = MODE_OAM;
                        nxt.line_count = '0;
                    end
                end
            endcase
        end
    end

endmodule

[design/lcd_mode_line_sequencer.sv]
`timescale 1ns / 1ps
// channel | direction | word                           | handshake
// s_*     | in        | tdata[7:0] elapsed_cycles      | s_tvalid & s_tready
// m_*     | out       | tdata mode, line; tuser flags  | m_tvalid & m_tready
// cfg_*   | in        | cfg_wdata[9:0] to reg cfg_addr | cfg_we
//
// one word per clock sustained while m_tready stays high; an accepted word passes through
// the input register, then the dot add and threshold compare into the result register
// reset returns the timing registers to defaults, mode hblank, line 0, dot count 0
// a stalled result holds the pipe; the input register still fills behind it

module lcd_mode_line_sequencer
    import lmls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] elapsed_cycles
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [1:0] mode, [9:2] line, [15:10] zero
    output logic [M_USER_W-1:0]  m_tuser,   // [0] render_line, [1] vblank_irq
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [THRESH_W-1:0]  cfg_wdata
);

    timing_cfg_t          cfg;
    seq_state_t           state_reg;
    seq_state_t           state_next;
    seq_flags_t           flags;
    seq_flags_t           flags_reg;
    logic                 in_valid_reg;
    logic [ELAPSED_W-1:0] in_data_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 step_fire;

    lmls_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmls_step u_step (
        .cur            (state_reg),
        .elapsed_cycles (in_data_reg),
        .cfg            (cfg),
        .nxt            (state_next),
        .flags          (flags)
    );

    assign advance   = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_HBLANK, dot_count: '0, line_count: '0};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[ELAPSED_W-1:0];
        end
        if (step_fire)
        begin
            flags_reg <= flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-MODE_W-LINE_W){1'b0}}, state_reg.line_count, state_reg.mode};
    assign m_tuser  = {flags_reg.vblank_irq, flags_reg.render_line};

endmodule

[design/lmls_checker.sv]
`timescale 1ns / 1ps

module lmls_checker
    import lmls_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // irq word must show the first vblank line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[1:0] == MODE_VBLANK && m_tdata[9:2] == VISIBLE_LINES)
        else $error("vblank_irq without vblank on line 144");

    // render strobe only when vram read just ended
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == MODE_HBLANK && !m_tuser[1])
        else $error("render_line outside hblank entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[9:2] <= LAST_LINE
                     && (m_tdata[1:0] == MODE_VBLANK || m_tdata[9:2] < VISIBLE_LINES))
        else $error("line out of range for mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind lcd_mode_line_sequencer lmls_checker u_lmls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
